[rtl/core/hfc_pkg.sv]
// Shared constants, types and the CRC byte step for the frame check and convert block.
`default_nettype none

package hfc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PROD_W  = 24;
  localparam int unsigned QUOT_W  = 8;
  localparam int unsigned HUM_W   = 7;
  localparam int unsigned TEMP_W  = 9;

  localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h31;
  localparam logic [BYTE_W-1:0] CRC_INIT    = 8'hFF;
  localparam logic [BYTE_W-1:0] HUM_SCALE   = 8'd100;
  localparam logic [BYTE_W-1:0] TEMP_SCALE  = 8'd175;
  localparam logic [15:0]       FULL_SCALE  = 16'hFFFF;
  localparam logic [QUOT_W-1:0] TEMP_OFFSET = 8'd45;

  // Stage enables handed from the control in the top level to each lane.
  typedef struct packed {
    logic en_a;
    logic en_b;
  } lane_ctrl_t;

  // What one lane found: check result, floor quotient and whether a remainder is left.
  typedef struct packed {
    logic              ok;
    logic [QUOT_W-1:0] quot;
    logic              rem_nz;
  } lane_res_t;

  // One byte through the CRC register, most significant bit first.
  function automatic logic [BYTE_W-1:0] crc_byte(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] c;
    c = v;
    for (int b = 0; b < BYTE_W; b++) begin
      if (c[BYTE_W-1]) begin
        c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[BYTE_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/core/hfc_in_if.sv]
// Request channel carrying one six-byte sensor reply frame.
`default_nettype none

interface hfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hum_msb;
  logic [7:0] hum_lsb;
  logic [7:0] hum_check;
  logic [7:0] temp_msb;
  logic [7:0] temp_lsb;
  logic [7:0] temp_check;

  modport source (
    output valid, hum_msb, hum_lsb, hum_check, temp_msb, temp_lsb, temp_check,
    input  ready
  );
  modport sink (
    input  valid, hum_msb, hum_lsb, hum_check, temp_msb, temp_lsb, temp_check,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/hfc_out_if.sv]
// Result channel carrying converted humidity and temperature with their check flags.
`default_nettype none

interface hfc_out_if;
  logic              valid;
  logic              ready;
  logic [6:0]        humidity_percent;
  logic              humidity_ok;
  logic signed [8:0] temperature_c;
  logic              temperature_ok;

  modport source (
    output valid, humidity_percent, humidity_ok, temperature_c, temperature_ok,
    input  ready
  );
  modport sink (
    input  valid, humidity_percent, humidity_ok, temperature_c, temperature_ok,
    output ready
  );
endinterface

`default_nettype wire

[rtl/core/humidity_temp_frame_check_convert_core.sv]
// Top level: two checking lanes, the merging stage and the pipeline control.
//
//   channel  direction  contents
//   in_i     request    hum_msb, hum_lsb, hum_check, temp_msb, temp_lsb, temp_check
//   out_o    result     humidity_percent, humidity_ok, temperature_c, temperature_ok
//
// A request is accepted every cycle unless the output stalls; its result passes through
// the two lane stages (one CRC byte each, product then division)
// and the output register of the merging stage.
// Reset clears only the stage valid bits; payload registers are not reset.
// A stalled result holds the output register, and the earlier stages keep filling
// until all three are occupied.
`default_nettype none

module humidity_temp_frame_check_convert_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hfc_in_if.sink    in_i,
  hfc_out_if.source out_o
);
  import hfc_pkg::*;

  logic       a_v_q, a_v_d;
  logic       b_v_q, b_v_d;
  logic       o_v_q, o_v_d;
  logic       en_a, en_b, en_o;
  lane_ctrl_t ctrl;
  lane_res_t  hum_res, temp_res;

  always_comb begin
    en_o = !o_v_q || out_o.ready;
    en_b = !b_v_q || en_o;
    en_a = !a_v_q || en_b;
    ctrl.en_a = en_a;
    ctrl.en_b = en_b;
    a_v_d = en_a ? in_i.valid : a_v_q;
    b_v_d = en_b ? a_v_q : b_v_q;
    o_v_d = en_o ? b_v_q : o_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      a_v_q <= a_v_d;
      b_v_q <= b_v_d;
      o_v_q <= o_v_d;
    end
  end

  assign in_i.ready  = en_a;
  assign out_o.valid = o_v_q;

  hfc_lane u_hum_lane (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .msb_i   (in_i.hum_msb),
    .lsb_i   (in_i.hum_lsb),
    .check_i (in_i.hum_check),
    .scale_i (HUM_SCALE),
    .res_o   (hum_res)
  );

  hfc_lane u_temp_lane (
    .clk_i   (clk_i),
    .ctrl_i  (ctrl),
    .msb_i   (in_i.temp_msb),
    .lsb_i   (in_i.temp_lsb),
    .check_i (in_i.temp_check),
    .scale_i (TEMP_SCALE),
    .res_o   (temp_res)
  );

  hfc_merge u_merge (
    .clk_i              (clk_i),
    .en_i               (en_o),
    .hum_i              (hum_res),
    .temp_i             (temp_res),
    .humidity_percent_o (out_o.humidity_percent),
    .humidity_ok_o      (out_o.humidity_ok),
    .temperature_c_o    (out_o.temperature_c),
    .temperature_ok_o   (out_o.temperature_ok)
  );

`ifndef SYNTHESIS
  a_hum_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.humidity_ok |-> out_o.humidity_percent == 7'd0)
    else $error("humidity not zero on failed check");

  a_temp_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.temperature_ok |-> out_o.temperature_c == 9'sd0)
    else $error("temperature not zero on failed check");

  a_hum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.humidity_percent <= 7'd100)
    else $error("humidity above full scale");

  a_temp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.temperature_c >= -9'sd45) && (out_o.temperature_c <= 9'sd130))
    else $error("temperature out of range");

  a_stage_b_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_v_q && o_v_q && !out_o.ready |=> b_v_q && a_v_q == $past(a_v_q || in_i.valid))
    else $error("stage B lost a request while stalled");
`endif

endmodule

`default_nettype wire

[rtl/core/hfc_lane.sv]
// One lane: CRC check of a 16-bit word and scaled division by full scale, two stages.
`default_nettype none

module hfc_lane (
  input  wire logic                      clk_i,
  input  wire hfc_pkg::lane_ctrl_t       ctrl_i,
  input  wire logic [7:0]                msb_i,
  input  wire logic [7:0]                lsb_i,
  input  wire logic [7:0]                check_i,
  input  wire logic [7:0]                scale_i,
  output hfc_pkg::lane_res_t             res_o
);
  import hfc_pkg::*;

  logic [BYTE_W-1:0] crc1_q, crc1_d;
  logic [BYTE_W-1:0] lsb_q;
  logic [BYTE_W-1:0] check_q;
  logic [PROD_W-1:0] prod_q, prod_d;
  lane_res_t         res_q, res_d;

  logic [BYTE_W-1:0] crc2;
  logic [QUOT_W-1:0] q0;
  logic [16:0]       r0;
  logic [16:0]       r1;
  logic              carry;

  // Stage A: first CRC byte and the scaling product.
  always_comb begin
    crc1_d = crc_byte(CRC_INIT ^ msb_i);
    prod_d = PROD_W'({msb_i, lsb_i}) * PROD_W'(scale_i);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_a) begin
      crc1_q  <= crc1_d;
      lsb_q   <= lsb_i;
      check_q <= check_i;
      prod_q  <= prod_d;
    end
  end

  // Stage B: second CRC byte, and division by 2^16-1 as a shift plus one correction.
  always_comb begin
    crc2  = crc_byte(crc1_q ^ lsb_q);
    q0    = prod_q[PROD_W-1:16];
    r0    = {1'b0, prod_q[15:0]} + 17'(q0);
    carry = (r0 >= {1'b0, FULL_SCALE});
    r1    = carry ? (r0 - {1'b0, FULL_SCALE}) : r0;
    res_d.ok     = (crc2 == check_q);
    res_d.quot   = carry ? (q0 + QUOT_W'(1)) : q0;
    res_d.rem_nz = (r1[15:0] != 16'd0);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_b) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

[rtl/core/hfc_merge.sv]
// Merging stage: turns both lane results into the output fields and registers them.
`default_nettype none

module hfc_merge (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire hfc_pkg::lane_res_t  hum_i,
  input  wire hfc_pkg::lane_res_t  temp_i,
  output logic [6:0]               humidity_percent_o,
  output logic                     humidity_ok_o,
  output logic signed [8:0]        temperature_c_o,
  output logic                     temperature_ok_o
);
  import hfc_pkg::*;

  logic [HUM_W-1:0]  hum_d, hum_q;
  logic [TEMP_W-1:0] temp_d, temp_q;
  logic              hum_ok_q, temp_ok_q;
  logic              round_up;

  // Below the offset the difference is negative, so truncation toward zero takes the ceiling.
  always_comb begin
    round_up = (temp_i.quot < TEMP_OFFSET) && temp_i.rem_nz;
    hum_d    = hum_i.ok ? hum_i.quot[HUM_W-1:0] : '0;
    if (temp_i.ok) begin
      temp_d = TEMP_W'(temp_i.quot) + TEMP_W'(round_up) - TEMP_W'(TEMP_OFFSET);
    end else begin
      temp_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hum_q     <= hum_d;
      hum_ok_q  <= hum_i.ok;
      temp_q    <= temp_d;
      temp_ok_q <= temp_i.ok;
    end
  end

  assign humidity_percent_o = hum_q;
  assign humidity_ok_o      = hum_ok_q;
  assign temperature_c_o    = $signed(temp_q);
  assign temperature_ok_o   = temp_ok_q;

endmodule

`default_nettype wire
